@@ src/slui_pkg.sv @@
package slui_pkg;

   localparam int DEFAULT_LIST_DEPTH = 16;
   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      CMD_APPEND_FIRST  = 2'd0,
      CMD_APPEND_SECOND = 2'd1,
      CMD_RUN           = 2'd2
   } command_type;

   localparam logic MODE_UNION        = 1'b0;
   localparam logic MODE_INTERSECTION = 1'b1;

   typedef struct packed {
      logic append_first;
      logic append_second;
      logic start;
      logic step;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
      logic out_free;
   } dp_stat_type;

endpackage

@@ src/slui_ctrl.sv @@
module slui_ctrl import slui_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (command_type'(req_tuser))
                  CMD_APPEND_FIRST:  cmd.append_first = 1'b1;
                  CMD_APPEND_SECOND: cmd.append_second = 1'b1;
                  CMD_RUN: begin
                     cmd.start = 1'b1;
                     state_in  = ST_WALK;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (stat.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/slui_dp.sv @@
module slui_dp import slui_pkg::*; #(
   parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   input  logic [VALUE_W-1:0] append_value,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [VALUE_W-1:0] rsp_tdata,
   output logic               rsp_tlast,
   output logic [1:0]         rsp_tuser
);

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   logic signed [VALUE_W-1:0] first_list [LIST_DEPTH];
   logic signed [VALUE_W-1:0] second_list [LIST_DEPTH];

   logic [CNT_W-1:0] first_count_ff, first_count_in;
   logic [CNT_W-1:0] second_count_ff, second_count_in;
   logic [CNT_W-1:0] first_ptr_ff, first_ptr_in;
   logic [CNT_W-1:0] second_ptr_ff, second_ptr_in;
   logic             dropped_ff, dropped_in;
   logic             mode_ff, mode_in;
   logic             pend_valid_ff, pend_valid_in;
   logic signed [VALUE_W-1:0] pend_value_ff, pend_value_in;
   logic             out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0] out_value_ff, out_value_in;
   logic             out_last_ff, out_last_in;
   logic             out_empty_ff, out_empty_in;
   logic             out_ovf_ff, out_ovf_in;

   logic signed [VALUE_W-1:0] a, b, emit_value;
   logic have_a, have_b, adv_a, adv_b, emit, done, out_free, stall, step_go;
   logic first_full, second_full;

   assign a      = first_list[first_ptr_ff[IDX_W-1:0]];
   assign b      = second_list[second_ptr_ff[IDX_W-1:0]];
   assign have_a = first_ptr_ff < first_count_ff;
   assign have_b = second_ptr_ff < second_count_ff;

   always_comb begin
      adv_a      = 1'b0;
      adv_b      = 1'b0;
      emit       = 1'b0;
      emit_value = a;
      if (mode_ff == MODE_UNION) begin
         if (have_a && have_b) begin
            if (!(b < a)) begin
               adv_a = 1'b1;
            end else begin
               adv_b      = 1'b1;
               emit_value = b;
            end
         end else if (have_a) begin
            adv_a = 1'b1;
         end else if (have_b) begin
            adv_b      = 1'b1;
            emit_value = b;
         end
         // A value equal to the one held back is a duplicate and is skipped.
         emit = (adv_a || adv_b) && !(pend_valid_ff && (pend_value_ff == emit_value));
         done = !have_a && !have_b;
      end else begin
         if (have_a && have_b) begin
            if (a < b) begin
               adv_a = 1'b1;
            end else if (b < a) begin
               adv_b = 1'b1;
            end else begin
               adv_a = 1'b1;
               adv_b = 1'b1;
               emit  = 1'b1;
            end
         end
         done = !(have_a && have_b);
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;
   assign stall    = emit && pend_valid_ff && !out_free;
   assign step_go  = cmd.step && !done && !stall;

   assign stat.done     = done;
   assign stat.out_free = out_free;

   assign first_full  = first_count_ff == CNT_W'(LIST_DEPTH);
   assign second_full = second_count_ff == CNT_W'(LIST_DEPTH);

   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      first_ptr_in    = first_ptr_ff;
      second_ptr_in   = second_ptr_ff;
      mode_in         = csr_wr_en ? csr_wr_data : mode_ff;
      pend_valid_in   = pend_valid_ff;
      pend_value_in   = pend_value_ff;
      out_valid_in    = out_valid_ff && !rsp_tready;
      out_value_in    = out_value_ff;
      out_last_in     = out_last_ff;
      out_empty_in    = out_empty_ff;
      out_ovf_in      = out_ovf_ff;

      if (cmd.append_first) begin
         if (first_full) begin
            dropped_in = 1'b1;
         end else begin
            first_count_in = first_count_ff + CNT_W'(1);
         end
      end
      if (cmd.append_second) begin
         if (second_full) begin
            dropped_in = 1'b1;
         end else begin
            second_count_in = second_count_ff + CNT_W'(1);
         end
      end
      if (cmd.start) begin
         first_ptr_in  = '0;
         second_ptr_in = '0;
         pend_valid_in = 1'b0;
      end
      if (step_go) begin
         first_ptr_in  = first_ptr_ff + CNT_W'(adv_a);
         second_ptr_in = second_ptr_ff + CNT_W'(adv_b);
         if (emit) begin
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_value_in = pend_value_ff;
               out_last_in  = 1'b0;
               out_empty_in = 1'b0;
               out_ovf_in   = dropped_ff;
            end
            pend_valid_in = 1'b1;
            pend_value_in = emit_value;
         end
      end
      if (cmd.finish) begin
         out_valid_in    = 1'b1;
         out_value_in    = pend_valid_ff ? pend_value_ff : '0;
         out_last_in     = 1'b1;
         out_empty_in    = !pend_valid_ff;
         out_ovf_in      = dropped_ff;
         pend_valid_in   = 1'b0;
         first_count_in  = '0;
         second_count_in = '0;
         dropped_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append_first && !first_full) begin
         first_list[first_count_ff[IDX_W-1:0]] <= append_value;
      end
      if (cmd.append_second && !second_full) begin
         second_list[second_count_ff[IDX_W-1:0]] <= append_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
         mode_ff         <= MODE_UNION;
         pend_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
         mode_ff         <= mode_in;
         pend_valid_ff   <= pend_valid_in;
         out_valid_ff    <= out_valid_in;
      end
      first_ptr_ff  <= first_ptr_in;
      second_ptr_ff <= second_ptr_in;
      pend_value_ff <= pend_value_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
      out_empty_ff  <= out_empty_in;
      out_ovf_ff    <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_ovf_ff, out_empty_ff};

endmodule

@@ src/sorted_list_union_intersection_unit.sv @@
// Sorted list union and intersection unit.
// Request transactions carry a command in req_tuser and a signed value in req_tdata.
// Commands append the value to the first or the second list, or run a merge of both
// lists, which are expected in ascending order. Appends give no response; an append to
// a full list is dropped and sets the overflow flag. A run walks both lists with
// one pointer each, one element per cycle unless a stalled response pauses it, and
// no request is accepted until the run has finished and its last result is queued.
// Each emitted value leaves as one response transaction; one value is held back so
// that the final one can carry rsp_tlast. A run with no result gives one transaction
// flagged empty. The csr_wr_en/csr_wr_data port selects union (0) or intersection (1)
// and must only be written while the unit is idle.
// Responses sit in an output register: a new request is taken while the final result
// of the previous run still waits, and a stalled rsp_tready pauses the walk.
// Synchronous reset empties both lists, clears the overflow flag, selects union mode
// and drops any pending response.
module sorted_list_union_intersection_unit import slui_pkg::*; #(
   parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [VALUE_W-1:0] req_tdata,  // [31:0] value
   input  logic [1:0]         req_tuser,  // [1:0] command
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [VALUE_W-1:0] rsp_tdata,  // [31:0] result_value
   output logic               rsp_tlast,
   output logic [1:0]         rsp_tuser,  // [0] empty_res, [1] overflow
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   slui_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   slui_dp #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .append_value (req_tdata),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

@@ src/slui_checker.sv @@
module slui_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)
         && $stable(rsp_tuser))
      else $error("Stalled response transaction changed.");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == 32'd0))
      else $error("Empty response transaction is not a final zero item.");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("Response valid straight after reset.");

   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid
         |-> rsp_tuser[1] == $past(rsp_tuser[1]))
      else $error("Overflow flag changed within one run.");

endmodule

bind sorted_list_union_intersection_unit slui_checker u_slui_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
